FILE: rtl/buh_pkg.sv
// shared types, constants and codes of the budgeted undo/redo history
package buh_pkg;

  localparam int TAG_W         = 16;
  localparam int COST_W        = 16;
  localparam int TOTAL_W       = 22;
  localparam int DEPTH_OUT_W   = 7;
  localparam int EVICT_W       = 7;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [EVICT_W-1:0] EVICT_MAX = {EVICT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_UNDO  = 2'd1,
    KIND_REDO  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RUN     = 3'd1,
    ACT_UNDO    = 3'd2,
    ACT_RERUN   = 3'd3,
    ACT_CLEARED = 3'd4
  } action_t;

  typedef enum logic {
    ALU_ADD_SAT   = 1'b0,
    ALU_SUB_FLOOR = 1'b1
  } alu_op_t;

  // one history entry as held in either store
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [COST_W-1:0] cost;
  } entry_t;

  // operand bundle for the shared arithmetic unit
  typedef struct packed {
    alu_op_t            op;
    logic [TOTAL_W-1:0] a;
    logic [TOTAL_W-1:0] b;
  } alu_req_t;

endpackage

FILE: rtl/budgeted_undo_redo_history.sv
// top level of the budgeted undo/redo history: sequencer, stores and shared unit
//
// Keeps an undo ring and a redo stack of command tags with their costs, and a
// running total of memory held. One request is worked at a time; in_stall is
// high from the cycle after acceptance until the sequencer returns to idle. A
// request is accepted while an earlier result still waits on the output
// register, but its own result is only loaded once that register is free.
// Clear, or undo/redo on an empty (or full) store, goes straight to the result;
// undo and redo do one store read and one move; execute adds the cost, takes
// off the redo total, drops the oldest entry first if the undo ring is full,
// pushes, then drops oldest entries while the total is over budget. The pace
// is set by the one shared add/subtract unit and the registered read port of
// the undo store: each dropped entry needs a read of its cost, a subtract from
// the total and a fresh compare against the budget. The next request can be
// accepted in the same cycle that out_valid rises. The budget register may be
// written at any time through cfg_valid/cfg_ready but is meant to change only
// while the block is idle. Stores need no clearing pass after reset.
module budgeted_undo_redo_history #(
  parameter int HISTORY_DEPTH = buh_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [buh_pkg::TAG_W-1:0]         in_command_tag,
  input  logic [buh_pkg::COST_W-1:0]        in_cost,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_action,
  output logic [buh_pkg::TAG_W-1:0]         out_acted_tag,
  output logic [buh_pkg::DEPTH_OUT_W-1:0]   out_undo_depth,
  output logic [buh_pkg::DEPTH_OUT_W-1:0]   out_redo_depth,
  output logic [buh_pkg::TOTAL_W-1:0]       out_memory_in_use,
  output logic [buh_pkg::EVICT_W-1:0]       out_evicted_count,
  // budget register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [buh_pkg::TOTAL_W-1:0]       cfg_memory_budget
);

  localparam int IW = $clog2(HISTORY_DEPTH);        // store index
  localparam int FW = $clog2(HISTORY_DEPTH + 1);    // fill count, holds the depth
  localparam int SW = IW + 1;                       // ring index sum before wrap
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(HISTORY_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_ADD,   // total += new cost
    S_EX_SUB,   // total -= redo total, redo discarded
    S_EV_RD,    // read cost of oldest undo entry
    S_EV_SUB,   // drop oldest undo entry
    S_PUSH,     // write new entry on top of undo ring
    S_CHECK,    // compare total against budget
    S_UN_RD,
    S_UN_MV,
    S_RE_RD,
    S_RE_MV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // control and running state
  logic [buh_pkg::TOTAL_W-1:0] budget_r;
  logic [IW-1:0]               oldest_r, oldest_nxt;
  logic [FW-1:0]               undo_fill_r, undo_fill_nxt;
  logic [FW-1:0]               redo_fill_r, redo_fill_nxt;
  logic [buh_pkg::TOTAL_W-1:0] redo_total_r, redo_total_nxt;
  logic [buh_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                        push_pend_r, push_pend_nxt;

  // request being worked
  logic [buh_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [buh_pkg::COST_W-1:0]  cost_r, cost_nxt;
  buh_pkg::action_t            action_r, action_nxt;
  logic [buh_pkg::TAG_W-1:0]   acted_r, acted_nxt;
  logic [buh_pkg::EVICT_W-1:0] evicted_r, evicted_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  buh_pkg::action_t                  o_action_r, o_action_nxt;
  logic [buh_pkg::TAG_W-1:0]         o_tag_r, o_tag_nxt;
  logic [buh_pkg::DEPTH_OUT_W-1:0]   o_undo_r, o_undo_nxt;
  logic [buh_pkg::DEPTH_OUT_W-1:0]   o_redo_r, o_redo_nxt;
  logic [buh_pkg::TOTAL_W-1:0]       o_mem_r, o_mem_nxt;
  logic [buh_pkg::EVICT_W-1:0]       o_evict_r, o_evict_nxt;

  // store ports
  logic            undo_wr_en, undo_rd_en;
  logic [IW-1:0]   undo_wr_addr, undo_rd_addr;
  buh_pkg::entry_t undo_wr_data, undo_rd_data;
  logic            redo_wr_en, redo_rd_en;
  logic [IW-1:0]   redo_wr_addr, redo_rd_addr;
  buh_pkg::entry_t redo_wr_data, redo_rd_data;

  // shared arithmetic unit
  buh_pkg::alu_req_t           alu_req;
  logic [buh_pkg::TOTAL_W-1:0] alu_res;
  logic                        alu_gt;

  // ring slot: oldest plus offset, wrapped once
  logic [FW-1:0] slot_off;
  logic [SW-1:0] slot_sum;
  logic [IW-1:0] slot_idx;
  logic [IW-1:0] oldest_inc;
  logic          out_free;

  assign slot_off   = (state_r == S_UN_RD) ? undo_fill_r - FW'(1) : undo_fill_r;
  assign slot_sum   = SW'(oldest_r) + SW'(slot_off);
  assign slot_idx   = (slot_sum >= DEPTH_S) ? IW'(slot_sum - DEPTH_S) : IW'(slot_sum);
  assign oldest_inc = (oldest_r == LAST_IDX) ? '0 : oldest_r + IW'(1);
  assign out_free   = !out_valid_r || !out_stall;

  buh_store #(.DEPTH(HISTORY_DEPTH), .AW(IW)) u_undo (
    .clk     (clk),
    .wr_en   (undo_wr_en),
    .wr_addr (undo_wr_addr),
    .wr_data (undo_wr_data),
    .rd_en   (undo_rd_en),
    .rd_addr (undo_rd_addr),
    .rd_data (undo_rd_data)
  );

  buh_store #(.DEPTH(HISTORY_DEPTH), .AW(IW)) u_redo (
    .clk     (clk),
    .wr_en   (redo_wr_en),
    .wr_addr (redo_wr_addr),
    .wr_data (redo_wr_data),
    .rd_en   (redo_rd_en),
    .rd_addr (redo_rd_addr),
    .rd_data (redo_rd_data)
  );

  buh_alu u_alu (
    .req    (alu_req),
    .res    (alu_res),
    .a_gt_b (alu_gt)
  );

  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    undo_fill_nxt  = undo_fill_r;
    redo_fill_nxt  = redo_fill_r;
    redo_total_nxt = redo_total_r;
    total_nxt      = total_r;
    push_pend_nxt  = push_pend_r;
    tag_nxt        = tag_r;
    cost_nxt       = cost_r;
    action_nxt     = action_r;
    acted_nxt      = acted_r;
    evicted_nxt    = evicted_r;
    out_valid_nxt  = out_valid_r && out_stall;
    o_action_nxt   = o_action_r;
    o_tag_nxt      = o_tag_r;
    o_undo_nxt     = o_undo_r;
    o_redo_nxt     = o_redo_r;
    o_mem_nxt      = o_mem_r;
    o_evict_nxt    = o_evict_r;

    undo_wr_en   = 1'b0;
    undo_wr_addr = slot_idx;
    undo_wr_data = '{tag: tag_r, cost: cost_r};
    undo_rd_en   = 1'b0;
    undo_rd_addr = oldest_r;
    redo_wr_en   = 1'b0;
    redo_wr_addr = IW'(redo_fill_r);
    redo_wr_data = undo_rd_data;
    redo_rd_en   = 1'b0;
    redo_rd_addr = IW'(redo_fill_r - FW'(1));

    alu_req.op = buh_pkg::ALU_SUB_FLOOR;
    alu_req.a  = total_r;
    alu_req.b  = budget_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tag_nxt     = in_command_tag;
          cost_nxt    = in_cost;
          action_nxt  = buh_pkg::ACT_NONE;
          acted_nxt   = '0;
          evicted_nxt = '0;
          state_nxt   = S_DONE;
          case (buh_pkg::kind_t'(in_kind))
            buh_pkg::KIND_EXEC: begin
              action_nxt = buh_pkg::ACT_RUN;
              acted_nxt  = in_command_tag;
              state_nxt  = S_EX_ADD;
            end
            buh_pkg::KIND_UNDO: begin
              if (undo_fill_r != '0 && redo_fill_r != FILL_FULL) begin
                state_nxt = S_UN_RD;
              end
            end
            buh_pkg::KIND_REDO: begin
              if (redo_fill_r != '0 && undo_fill_r != FILL_FULL) begin
                state_nxt = S_RE_RD;
              end
            end
            buh_pkg::KIND_CLEAR: begin
              action_nxt     = buh_pkg::ACT_CLEARED;
              undo_fill_nxt  = '0;
              redo_fill_nxt  = '0;
              redo_total_nxt = '0;
              total_nxt      = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_EX_ADD: begin
        alu_req.op = buh_pkg::ALU_ADD_SAT;
        alu_req.b  = buh_pkg::TOTAL_W'(cost_r);
        total_nxt  = alu_res;
        state_nxt  = S_EX_SUB;
      end
      S_EX_SUB: begin
        alu_req.b      = redo_total_r;
        total_nxt      = alu_res;
        redo_fill_nxt  = '0;
        redo_total_nxt = '0;
        // full ring: make room before the push
        if (undo_fill_r == FILL_FULL) begin
          push_pend_nxt = 1'b1;
          state_nxt     = S_EV_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_EV_RD: begin
        undo_rd_en   = 1'b1;
        undo_rd_addr = oldest_r;
        state_nxt    = S_EV_SUB;
      end
      S_EV_SUB: begin
        alu_req.b     = buh_pkg::TOTAL_W'(undo_rd_data.cost);
        total_nxt     = alu_res;
        oldest_nxt    = oldest_inc;
        undo_fill_nxt = undo_fill_r - FW'(1);
        if (evicted_r != buh_pkg::EVICT_MAX) begin
          evicted_nxt = evicted_r + buh_pkg::EVICT_W'(1);
        end
        if (push_pend_r) begin
          push_pend_nxt = 1'b0;
          state_nxt     = S_PUSH;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_PUSH: begin
        undo_wr_en    = 1'b1;
        undo_wr_data  = '{tag: tag_r, cost: cost_r};
        undo_fill_nxt = undo_fill_r + FW'(1);
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        // same unit, compare only: total against budget
        if (alu_gt && undo_fill_r != '0) begin
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UN_RD: begin
        undo_rd_en   = 1'b1;
        undo_rd_addr = slot_idx;
        state_nxt    = S_UN_MV;
      end
      S_UN_MV: begin
        redo_wr_en     = 1'b1;
        redo_wr_data   = undo_rd_data;
        alu_req.op     = buh_pkg::ALU_ADD_SAT;
        alu_req.a      = redo_total_r;
        alu_req.b      = buh_pkg::TOTAL_W'(undo_rd_data.cost);
        redo_total_nxt = alu_res;
        redo_fill_nxt  = redo_fill_r + FW'(1);
        undo_fill_nxt  = undo_fill_r - FW'(1);
        action_nxt     = buh_pkg::ACT_UNDO;
        acted_nxt      = undo_rd_data.tag;
        state_nxt      = S_DONE;
      end
      S_RE_RD: begin
        redo_rd_en = 1'b1;
        state_nxt  = S_RE_MV;
      end
      S_RE_MV: begin
        undo_wr_en     = 1'b1;
        undo_wr_data   = redo_rd_data;
        alu_req.a      = redo_total_r;
        alu_req.b      = buh_pkg::TOTAL_W'(redo_rd_data.cost);
        redo_total_nxt = alu_res;
        redo_fill_nxt  = redo_fill_r - FW'(1);
        undo_fill_nxt  = undo_fill_r + FW'(1);
        action_nxt     = buh_pkg::ACT_RERUN;
        acted_nxt      = redo_rd_data.tag;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_action_nxt  = action_r;
          o_tag_nxt     = acted_r;
          o_undo_nxt    = buh_pkg::DEPTH_OUT_W'(undo_fill_r);
          o_redo_nxt    = buh_pkg::DEPTH_OUT_W'(redo_fill_r);
          o_mem_nxt     = total_r;
          o_evict_nxt   = evicted_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      budget_r     <= buh_pkg::TOTAL_MAX;
      oldest_r     <= '0;
      undo_fill_r  <= '0;
      redo_fill_r  <= '0;
      redo_total_r <= '0;
      total_r      <= '0;
      push_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oldest_r     <= oldest_nxt;
      undo_fill_r  <= undo_fill_nxt;
      redo_fill_r  <= redo_fill_nxt;
      redo_total_r <= redo_total_nxt;
      total_r      <= total_nxt;
      push_pend_r  <= push_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        budget_r <= cfg_memory_budget;
      end
    end
    // payload, no reset needed
    tag_r      <= tag_nxt;
    cost_r     <= cost_nxt;
    action_r   <= action_nxt;
    acted_r    <= acted_nxt;
    evicted_r  <= evicted_nxt;
    o_action_r <= o_action_nxt;
    o_tag_r    <= o_tag_nxt;
    o_undo_r   <= o_undo_nxt;
    o_redo_r   <= o_redo_nxt;
    o_mem_r    <= o_mem_nxt;
    o_evict_r  <= o_evict_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_action        = o_action_r;
  assign out_acted_tag     = o_tag_r;
  assign out_undo_depth    = o_undo_r;
  assign out_redo_depth    = o_redo_r;
  assign out_memory_in_use = o_mem_r;
  assign out_evicted_count = o_evict_r;

endmodule

FILE: rtl/buh_store.sv
// single-port-write, registered-read entry store for one history stack
module buh_store #(
  parameter int DEPTH = buh_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  buh_pkg::entry_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output buh_pkg::entry_t rd_data
);

  buh_pkg::entry_t mem_r [DEPTH];
  buh_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/buh_alu.sv
// shared saturating add / floored subtract unit with greater-than flag
module buh_alu (
  input  buh_pkg::alu_req_t            req,
  output logic [buh_pkg::TOTAL_W-1:0]  res,
  output logic                         a_gt_b
);

  logic [buh_pkg::TOTAL_W:0] sum;
  logic [buh_pkg::TOTAL_W:0] diff;
  logic                      borrow;

  assign sum    = {1'b0, req.a} + {1'b0, req.b};
  assign diff   = {1'b0, req.a} - {1'b0, req.b};
  assign borrow = diff[buh_pkg::TOTAL_W];
  assign a_gt_b = !borrow && (diff[buh_pkg::TOTAL_W-1:0] != '0);

  always_comb begin
    case (req.op)
      buh_pkg::ALU_ADD_SAT: begin
        res = sum[buh_pkg::TOTAL_W] ? buh_pkg::TOTAL_MAX : sum[buh_pkg::TOTAL_W-1:0];
      end
      buh_pkg::ALU_SUB_FLOOR: begin
        res = borrow ? '0 : diff[buh_pkg::TOTAL_W-1:0];
      end
      default: begin
        res = req.a;
      end
    endcase
  end

endmodule

FILE: rtl/buh_checker.sv
// port-level checks of the budgeted undo/redo history, bound to the top level
module buh_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [2:0]                        out_action,
  input logic [buh_pkg::TAG_W-1:0]         out_acted_tag,
  input logic [buh_pkg::DEPTH_OUT_W-1:0]   out_undo_depth,
  input logic [buh_pkg::DEPTH_OUT_W-1:0]   out_redo_depth,
  input logic [buh_pkg::TOTAL_W-1:0]       out_memory_in_use,
  input logic [buh_pkg::EVICT_W-1:0]       out_evicted_count
);

  // one request at a time: stall rises straight after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_acted_tag) && $stable(out_memory_in_use))
    else $error("stalled result changed");

  // clear leaves nothing behind
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == buh_pkg::ACT_CLEARED |->
      out_undo_depth == '0 && out_redo_depth == '0 &&
      out_memory_in_use == '0 && out_evicted_count == '0 && out_acted_tag == '0)
    else $error("clear result not empty");

  // only execute can drop entries
  a_evict_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_count != '0 |-> out_action == buh_pkg::ACT_RUN)
    else $error("eviction reported on a non-execute request");

  // no-op carries no tag
  a_none_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == buh_pkg::ACT_NONE |-> out_acted_tag == '0)
    else $error("no-op result carries a tag");

endmodule

bind budgeted_undo_redo_history buh_checker u_buh_checker (.*);
